>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the page allocator checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define PFLA_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pfla same-cycle check failed");

// next-cycle implication, disabled during reset
`define PFLA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pfla next-cycle check failed");

`endif

>>> rtl/pfla_pkg.sv
// ----------------------------------------------------------------------------
// pfla_pkg
// Types, codes and constants of the page free list allocator.
// ----------------------------------------------------------------------------
package pfla_pkg;

    localparam int PAGE_INDEX_BITS_DEF = 16;
    localparam int PAGE_W              = 16;
    localparam int COUNT_W             = 16;
    localparam int FREE_W              = 17;

    localparam logic [FREE_W-1:0] FREE_MAX = 17'h10000;

    typedef enum logic [1:0] {
        REQ_ADD   = 2'd0,
        REQ_ALLOC = 2'd1,
        REQ_FREE  = 2'd2
    } t_req;

    typedef enum logic [1:0] {
        OP_NOP,
        OP_ADD,
        OP_ALLOC,
        OP_FREE
    } t_op;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ADD,
        ST_ADD_END,
        ST_ALLOC
    } t_state;

    typedef struct packed {
        logic [1:0]         req_type;
        logic [PAGE_W-1:0]  page_number;
        logic [COUNT_W-1:0] region_pages;
        logic               region_free;
    } t_in;

    typedef struct packed {
        logic [PAGE_W-1:0] alloc_page;
        logic              list_empty;
        logic [FREE_W-1:0] pages_free;
    } t_out;

    typedef struct packed {
        t_op                op;
        logic [PAGE_W-1:0]  page;
        logic [COUNT_W-1:0] count;
    } t_cmd;

    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_cmd_q;

    function automatic int addr_bits(input int index_bits);
        return (index_bits < PAGE_W) ? index_bits : PAGE_W;
    endfunction

    function automatic logic [FREE_W-1:0] page_limit(input int index_bits);
        logic [63:0] lim;
        lim = (64'd1 << addr_bits(index_bits)) - 64'd1;
        return lim[FREE_W-1:0];
    endfunction

endpackage

>>> rtl/pfla_ram.sv
// ----------------------------------------------------------------------------
// pfla_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module pfla_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/pfla_front.sv
// ----------------------------------------------------------------------------
// pfla_front
// Accept requests, classify them into commands and queue them for the back end.
// ----------------------------------------------------------------------------
module pfla_front #(
    parameter int PAGE_INDEX_BITS = pfla_pkg::PAGE_INDEX_BITS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  pfla_pkg::t_in    i_in_data,
    output pfla_pkg::t_cmd_q o_cmd,
    input  logic             i_pop
);

    localparam logic [pfla_pkg::FREE_W-1:0] LIMIT = pfla_pkg::page_limit(PAGE_INDEX_BITS);

    pfla_pkg::t_cmd r_slot [2];
    logic           r_wr_ptr;
    logic           r_rd_ptr;
    logic [1:0]     r_count;

    pfla_pkg::t_cmd              cls;
    logic [pfla_pkg::PAGE_W-1:0] add_start;
    logic [pfla_pkg::COUNT_W-1:0] add_cnt;
    logic                        push;
    logic                        pop;

    always_comb begin
        add_start = (i_in_data.page_number == '0) ? 16'd1 : i_in_data.page_number;
        add_cnt   = (i_in_data.page_number == '0) ? (i_in_data.region_pages - 16'd1)
                                                  : i_in_data.region_pages;
        cls.op    = pfla_pkg::OP_NOP;
        cls.page  = add_start;
        cls.count = add_cnt;
        unique case (pfla_pkg::t_req'(i_in_data.req_type))
            pfla_pkg::REQ_ADD: begin
                if (i_in_data.region_free && (i_in_data.region_pages != '0) &&
                    (add_cnt != '0) && ({1'b0, add_start} <= LIMIT)) begin
                    cls.op = pfla_pkg::OP_ADD;
                end
            end
            pfla_pkg::REQ_ALLOC: begin
                cls.op = pfla_pkg::OP_ALLOC;
            end
            pfla_pkg::REQ_FREE: begin
                cls.page = i_in_data.page_number;
                if ((i_in_data.page_number != '0) &&
                    ({1'b0, i_in_data.page_number} <= LIMIT)) begin
                    cls.op = pfla_pkg::OP_FREE;
                end
            end
            default: begin
                cls.op = pfla_pkg::OP_NOP;
            end
        endcase
    end

    assign o_in_stall = (r_count == 2'd2);
    assign push       = i_in_valid && !o_in_stall;
    assign pop        = i_pop && (r_count != 2'd0);

    assign o_cmd.valid = (r_count != 2'd0);
    assign o_cmd.cmd   = r_slot[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_slot[r_wr_ptr] <= cls;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            unique case ({push, pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

>>> rtl/pfla_back.sv
// ----------------------------------------------------------------------------
// pfla_back
// Execute queued commands on the link table and hold the result register.
// ----------------------------------------------------------------------------
module pfla_back #(
    parameter int PAGE_INDEX_BITS = pfla_pkg::PAGE_INDEX_BITS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  pfla_pkg::t_cmd_q i_cmd,
    output logic             o_pop,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output pfla_pkg::t_out   o_out_data
);

    localparam int AW = pfla_pkg::addr_bits(PAGE_INDEX_BITS);
    localparam int DEPTH = 1 << AW;
    localparam logic [pfla_pkg::FREE_W-1:0] LIMIT = pfla_pkg::page_limit(PAGE_INDEX_BITS);

    pfla_pkg::t_state              r_state, n_state;
    logic [pfla_pkg::PAGE_W-1:0]   r_head, n_head;
    logic [pfla_pkg::PAGE_W-1:0]   r_tail, n_tail;
    logic [pfla_pkg::FREE_W-1:0]   r_free, n_free;
    logic [pfla_pkg::FREE_W-1:0]   r_page, n_page;
    logic [pfla_pkg::COUNT_W-1:0]  r_cnt, n_cnt;
    logic                          r_out_valid;
    pfla_pkg::t_out                r_out_data;

    logic                          out_free;
    logic                          pop;
    logic                          add_last;
    logic [pfla_pkg::FREE_W-1:0]   page_nxt;
    logic [pfla_pkg::FREE_W-1:0]   free_inc;
    logic [pfla_pkg::FREE_W-1:0]   free_dec;
    logic                          res_valid;
    pfla_pkg::t_out                res;
    logic                          we;
    logic [AW-1:0]                 waddr;
    logic [pfla_pkg::PAGE_W-1:0]   wdata;
    logic [pfla_pkg::PAGE_W-1:0]   rdata;

    assign out_free = !r_out_valid || !i_out_stall;
    assign pop      = (r_state == pfla_pkg::ST_IDLE) && i_cmd.valid && out_free;
    assign o_pop    = pop;
    assign page_nxt = r_page + 17'd1;
    assign add_last = (r_cnt == 16'd1) || (page_nxt > LIMIT);
    assign free_inc = (r_free == pfla_pkg::FREE_MAX) ? r_free : (r_free + 17'd1);
    assign free_dec = (r_free == '0) ? r_free : (r_free - 17'd1);

    pfla_ram #(
        .WIDTH (pfla_pkg::PAGE_W),
        .DEPTH (DEPTH)
    ) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (r_head[AW-1:0]),
        .o_rdata (rdata)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            pfla_pkg::ST_IDLE: begin
                if (pop) begin
                    unique case (i_cmd.cmd.op)
                        pfla_pkg::OP_ADD:   n_state = pfla_pkg::ST_ADD;
                        pfla_pkg::OP_ALLOC: n_state = (r_head == '0) ? pfla_pkg::ST_IDLE
                                                                     : pfla_pkg::ST_ALLOC;
                        default:            n_state = pfla_pkg::ST_IDLE;
                    endcase
                end
            end
            pfla_pkg::ST_ADD: begin
                if (add_last) begin
                    n_state = pfla_pkg::ST_ADD_END;
                end
            end
            pfla_pkg::ST_ADD_END,
            pfla_pkg::ST_ALLOC: begin
                if (out_free) begin
                    n_state = pfla_pkg::ST_IDLE;
                end
            end
            default: n_state = pfla_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        n_head         = r_head;
        n_tail         = r_tail;
        n_free         = r_free;
        n_page         = r_page;
        n_cnt          = r_cnt;
        we             = 1'b0;
        waddr          = r_tail[AW-1:0];
        wdata          = '0;
        res_valid      = 1'b0;
        res.alloc_page = '0;
        res.list_empty = 1'b0;
        unique case (r_state)
            pfla_pkg::ST_IDLE: begin
                if (pop) begin
                    unique case (i_cmd.cmd.op)
                        pfla_pkg::OP_ADD: begin
                            n_page = {1'b0, i_cmd.cmd.page};
                            n_cnt  = i_cmd.cmd.count;
                        end
                        pfla_pkg::OP_ALLOC: begin
                            if (r_head == '0) begin
                                res_valid      = 1'b1;
                                res.list_empty = 1'b1;
                            end
                        end
                        pfla_pkg::OP_FREE: begin
                            if (r_head == '0) begin
                                n_tail = i_cmd.cmd.page;
                            end
                            we        = 1'b1;
                            waddr     = i_cmd.cmd.page[AW-1:0];
                            wdata     = r_head;
                            n_head    = i_cmd.cmd.page;
                            n_free    = free_inc;
                            res_valid = 1'b1;
                        end
                        default: begin
                            res_valid = 1'b1;
                        end
                    endcase
                end
            end
            pfla_pkg::ST_ADD: begin
                if (r_head == '0) begin
                    n_head = r_page[pfla_pkg::PAGE_W-1:0];
                end else begin
                    we    = 1'b1;
                    wdata = r_page[pfla_pkg::PAGE_W-1:0];
                end
                n_tail = r_page[pfla_pkg::PAGE_W-1:0];
                n_free = free_inc;
                n_page = page_nxt;
                n_cnt  = r_cnt - 16'd1;
            end
            pfla_pkg::ST_ADD_END: begin
                if (out_free) begin
                    we        = 1'b1;
                    res_valid = 1'b1;
                end
            end
            pfla_pkg::ST_ALLOC: begin
                if (out_free) begin
                    n_head         = rdata;
                    n_free         = free_dec;
                    res.alloc_page = r_head;
                    res_valid      = 1'b1;
                end
            end
            default: begin
                res_valid = 1'b0;
            end
        endcase
        res.pages_free = n_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= pfla_pkg::ST_IDLE;
            r_head      <= '0;
            r_tail      <= '0;
            r_free      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_free  <= n_free;
            if (res_valid) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_page <= n_page;
        r_cnt  <= n_cnt;
        if (res_valid) begin
            r_out_data <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

>>> rtl/page_free_list_allocator.sv
// ----------------------------------------------------------------------------
// page_free_list_allocator
// Physical page allocator: free pages on a linked list, links in a RAM table.
// Requests wait in a two-entry queue; the back end takes a new command only
// when idle, and links an added region one page per cycle.
// Reset clears head, tail, count and queue at once; the link RAM is not cleared.
// ----------------------------------------------------------------------------
module page_free_list_allocator #(
    parameter int PAGE_INDEX_BITS = pfla_pkg::PAGE_INDEX_BITS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  pfla_pkg::t_in  i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output pfla_pkg::t_out o_out_data
);

    pfla_pkg::t_cmd_q cmd;
    logic             pop;

    pfla_front #(
        .PAGE_INDEX_BITS (PAGE_INDEX_BITS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .o_cmd      (cmd),
        .i_pop      (pop)
    );

    pfla_back #(
        .PAGE_INDEX_BITS (PAGE_INDEX_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

>>> rtl/pfla_checker.sv
// ----------------------------------------------------------------------------
// pfla_checker
// Port-level checks of the page allocator, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pfla_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_out_valid,
    input logic           i_out_stall,
    input pfla_pkg::t_out i_out_data
);

    `PFLA_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && i_out_stall, i_out_valid)
    `PFLA_ASSERT_NEXT(a_out_stable, i_clk, i_rst_n, i_out_valid && i_out_stall, $stable(i_out_data))
    `PFLA_ASSERT_SAME(a_empty_no_page, i_clk, i_rst_n, i_out_valid && i_out_data.list_empty, i_out_data.alloc_page == 16'd0)
    `PFLA_ASSERT_SAME(a_count_max, i_clk, i_rst_n, i_out_valid, i_out_data.pages_free <= pfla_pkg::FREE_MAX)

endmodule

bind page_free_list_allocator pfla_checker u_pfla_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .i_out_data  (o_out_data)
);

>>> dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: page free list allocator testbench
// Drives add-region, allocate and free requests through the valid/stall
// handshake and predicts each report with a shadow copy of the free list.
// The shadow keeps the link table, head, tail and count. Each report is
// compared field by field with the oldest prediction. A directed opening
// covers page zero, regions that are not free or empty, pages past the top,
// empty allocates, unknown requests and duplicate pages. Random traffic with
// idle gaps on both sides follows. A final bulk region drives the count to
// saturation.
// ----------------------------------------------------------------------------
module tb;

    localparam int unsigned PAGE_TOP =
        (pfla_pkg::PAGE_INDEX_BITS_DEF < 16) ? (1 << pfla_pkg::PAGE_INDEX_BITS_DEF) - 1
                                             : 65535;
    localparam logic [1:0] REQ_UNKNOWN = 2'd3;
    localparam int         RANDOM_REQS = 480;
    localparam int         CYCLE_LIMIT = 3000000;
    localparam int         DRAIN_CYCLES = 10;

    class free_list_shadow;
        bit [15:0]       next_link [65536];
        bit [15:0]       head;
        bit [15:0]       tail;
        bit [16:0]       total;
        bit [16:0]       peak_total;
        bit [15:0]       handed_out[$];
        pfla_pkg::t_out  awaited_reports[$];
        int              errors;
        int              n_add, n_alloc, n_free, n_other, n_empty, n_checked;

        function void bump_total();
            if (total < 17'h10000) total++;
            if (total > peak_total) peak_total = total;
        endfunction

        function void note_request(pfla_pkg::t_in req);
            pfla_pkg::t_out rpt;
            int unsigned    pg;
            rpt = '0;
            case (req.req_type)
                pfla_pkg::REQ_ADD: begin
                    n_add++;
                    if (req.region_free) begin
                        for (int unsigned j = 0; j < req.region_pages; j++) begin
                            pg = req.page_number + j;
                            if (pg > PAGE_TOP) break;
                            if (pg != 0) begin
                                if (head == 0) head = pg[15:0];
                                else next_link[tail & PAGE_TOP] = pg[15:0];
                                next_link[pg & PAGE_TOP] = 16'd0;
                                tail = pg[15:0];
                                bump_total();
                            end
                        end
                    end
                end
                pfla_pkg::REQ_ALLOC: begin
                    n_alloc++;
                    if (head == 0) begin
                        rpt.list_empty = 1'b1;
                        n_empty++;
                    end else begin
                        rpt.alloc_page = head;
                        handed_out.push_back(head);
                        head = next_link[head & PAGE_TOP];
                        if (total > 0) total--;
                    end
                end
                pfla_pkg::REQ_FREE: begin
                    n_free++;
                    if (req.page_number != 0 && req.page_number <= PAGE_TOP) begin
                        if (head == 0) tail = req.page_number;
                        next_link[req.page_number & PAGE_TOP] = head;
                        head = req.page_number;
                        bump_total();
                    end
                end
                default: n_other++;
            endcase
            rpt.pages_free = total;
            awaited_reports.push_back(rpt);
        endfunction

        function void check_result(pfla_pkg::t_out got);
            pfla_pkg::t_out want;
            if (awaited_reports.size() == 0) begin
                $error("unexpected report: alloc_page %0d list_empty %0d pages_free %0d",
                       got.alloc_page, got.list_empty, got.pages_free);
                errors++;
                return;
            end
            want = awaited_reports.pop_front();
            n_checked++;
            if (got.alloc_page !== want.alloc_page) begin
                $error("alloc_page expected %0d actual %0d", want.alloc_page, got.alloc_page);
                errors++;
            end
            if (got.list_empty !== want.list_empty) begin
                $error("list_empty expected %0d actual %0d", want.list_empty, got.list_empty);
                errors++;
            end
            if (got.pages_free !== want.pages_free) begin
                $error("pages_free expected %0d actual %0d", want.pages_free, got.pages_free);
                errors++;
            end
        endfunction
    endclass

    logic            i_clk = 1'b0;
    logic            i_rst_n;
    logic            i_in_valid;
    logic            o_in_stall;
    pfla_pkg::t_in   i_in_data;
    logic            o_out_valid;
    logic            i_out_stall;
    pfla_pkg::t_out  o_out_data;

    free_list_shadow shadow;
    bit              calm;
    int              cycles;

    page_free_list_allocator uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    always #10 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            i_out_stall <= !calm && ($urandom_range(99) < 13);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            shadow.check_result(o_out_data);
        end
    end

    function automatic pfla_pkg::t_in make_req(logic [1:0] kind, logic [15:0] page,
                                               logic [15:0] count, logic is_free);
        pfla_pkg::t_in req;
        req.req_type     = kind;
        req.page_number  = page;
        req.region_pages = count;
        req.region_free  = is_free;
        return req;
    endfunction

    // enter and leave at a falling edge; valid is lowered only by an idle cycle
    task automatic send_req(pfla_pkg::t_in req);
        while (!calm && $urandom_range(99) < 13) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= req;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        shadow.note_request(req);
        @(negedge i_clk);
    endtask

    task automatic random_req(output pfla_pkg::t_in req);
        int          pick;
        int unsigned idx;
        logic        is_free;
        logic [15:0] page;
        logic [15:0] count;
        pick    = $urandom_range(99);
        page    = 16'($urandom);
        count   = 16'($urandom);
        is_free = 1'($urandom_range(1));
        if (pick < 5) begin
            req = make_req(REQ_UNKNOWN, page, count, is_free);
        end else if (pick < 37) begin
            req = make_req(pfla_pkg::REQ_ALLOC, page, count, is_free);
        end else if (pick < 67) begin
            if (shadow.handed_out.size() != 0 && $urandom_range(99) < 85) begin
                idx  = $urandom_range(shadow.handed_out.size() - 1);
                page = shadow.handed_out[idx];
                shadow.handed_out.delete(idx);
            end else if ($urandom_range(99) < 20) begin
                page = 16'd0;
            end
            req = make_req(pfla_pkg::REQ_FREE, page, count, is_free);
        end else begin
            is_free = $urandom_range(99) < 85;
            if (!is_free) begin
                // ignored region, any size
            end else if ($urandom_range(99) < 4) begin
                page = 16'(PAGE_TOP - $urandom_range(40));
            end else begin
                if ($urandom_range(99) < 10) page = 16'($urandom_range(3));
                count = 16'($urandom_range(24));
            end
            req = make_req(pfla_pkg::REQ_ADD, page, count, is_free);
        end
    endtask

    initial begin
        pfla_pkg::t_in req;
        shadow      = new();
        calm        = 1'b0;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_data   = '0;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        send_req(make_req(pfla_pkg::REQ_ALLOC, 16'hffff, 16'hffff, 1'b1));
        send_req(make_req(REQ_UNKNOWN, 16'hffff, 16'hffff, 1'b1));
        send_req(make_req(pfla_pkg::REQ_FREE, 16'd0, 16'd0, 1'b0));
        send_req(make_req(pfla_pkg::REQ_ADD, 16'd5, 16'd3, 1'b0));
        send_req(make_req(pfla_pkg::REQ_ADD, 16'd5, 16'd0, 1'b1));
        send_req(make_req(pfla_pkg::REQ_ADD, 16'd0, 16'd3, 1'b1));
        send_req(make_req(pfla_pkg::REQ_ADD, 16'hfffe, 16'hffff, 1'b1));
        send_req(make_req(pfla_pkg::REQ_FREE, 16'hffff, 16'd0, 1'b0));
        repeat (6) send_req(make_req(pfla_pkg::REQ_ALLOC, 16'd0, 16'd0, 1'b0));
        send_req(make_req(pfla_pkg::REQ_FREE, 16'd7, 16'd0, 1'b0));
        send_req(make_req(pfla_pkg::REQ_ADD, 16'd100, 16'd2, 1'b1));
        send_req(make_req(pfla_pkg::REQ_ADD, 16'd101, 16'd1, 1'b1));
        repeat (4) send_req(make_req(pfla_pkg::REQ_ALLOC, 16'd0, 16'd0, 1'b0));
        send_req(make_req(REQ_UNKNOWN, 16'd0, 16'd0, 1'b0));

        // hold off until every report of the opening has arrived
        i_in_valid <= 1'b0;
        while (shadow.awaited_reports.size() != 0) @(negedge i_clk);

        for (int n = 0; n < RANDOM_REQS; n++) begin
            calm = (n >= 200 && n < 300);
            random_req(req);
            send_req(req);
        end
        calm = 1'b0;

        // drive the count to saturation with one full-size region
        send_req(make_req(pfla_pkg::REQ_ADD, 16'd0, 16'hffff, 1'b1));
        send_req(make_req(pfla_pkg::REQ_FREE, 16'h1234, 16'd0, 1'b0));
        send_req(make_req(pfla_pkg::REQ_FREE, 16'h00ff, 16'd0, 1'b0));
        repeat (3) send_req(make_req(pfla_pkg::REQ_ALLOC, 16'd0, 16'd0, 1'b0));
        i_in_valid <= 1'b0;

        while (shadow.awaited_reports.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("tb: %0d requests sent: %0d add, %0d allocate, %0d free, %0d unknown",
                 shadow.n_add + shadow.n_alloc + shadow.n_free + shadow.n_other,
                 shadow.n_add, shadow.n_alloc, shadow.n_free, shadow.n_other);
        $display("tb: %0d reports checked, %0d empty allocates, free count peaked at %0d",
                 shadow.n_checked, shadow.n_empty, shadow.peak_total);
        if (shadow.errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule
